>>> hdl/mmc_pkg.sv
// ----------------------------------------------------------------------------
// mmc_pkg
// Shared widths, constants, types and helper functions of the multirotor
// mixer coefficient generator.
// ----------------------------------------------------------------------------
`default_nettype none

package mmc_pkg;

    // fixed point result format, Q24.24
    localparam int QW = 48;
    localparam int FRAC_SHIFT = 8;     // Q16.16 to Q24.24

    localparam logic signed [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
    localparam logic signed [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

    // default number of matrix columns
    localparam int MAX_MOTORS_DEF = 8;

    // angle unit, 24 fraction bits
    localparam int CW = 28;
    localparam int ANG_SHIFT = 11;     // Q3.13 to 24 fraction bits
    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_PER_STAGE = 2;
    localparam int CORDIC_STAGES = CORDIC_STEPS / CORDIC_PER_STAGE;
    localparam logic signed [CW-1:0] PI_Q24 = CW'(52707179);
    localparam logic signed [CW-1:0] HALF_PI_Q24 = CW'(26353589);
    localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(10188014);

    // divider, quotient bits retired per stage
    localparam int DIVW = 48;
    localparam int DIV_BITS = 4;
    localparam int DIV_STAGES = DIVW / DIV_BITS;

    // multiplier latency in cycles
    localparam int QMUL_LAT = 4;

    // axis codes
    localparam int NAXES = 6;
    localparam logic [2:0] AXIS_X = 3'd0;
    localparam logic [2:0] AXIS_Y = 3'd1;
    localparam logic [2:0] AXIS_Z = 3'd2;
    localparam logic [2:0] AXIS_ROLL = 3'd3;
    localparam logic [2:0] AXIS_PITCH = 3'd4;
    localparam logic [2:0] AXIS_YAW = 3'd5;

    // configuration register indexes
    localparam logic REG_AXIS_ENABLE = 1'b0;
    localparam logic [5:0] AXIS_ENABLE_RST = 6'd63;

    // per-motor side band carried down the pipeline
    typedef struct packed {
        logic [2:0]  col;
        logic        spin;
        logic [31:0] tg;
        logic [31:0] cg;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
    } side_t;

    // arctangent table, 24 fraction bits
    function automatic logic signed [CW-1:0] cordic_atan(input int unsigned i);
        logic signed [CW-1:0] v;
        case (i)
            0:       v = CW'(13176795);
            1:       v = CW'(7778716);
            2:       v = CW'(4110060);
            3:       v = CW'(2086331);
            4:       v = CW'(1047214);
            5:       v = CW'(524117);
            6:       v = CW'(262123);
            7:       v = CW'(131069);
            default: v = (i < 24) ? (CW'(1) <<< (24 - i)) : '0;
        endcase
        return v;
    endfunction

    // Q16.16 to Q24.24
    function automatic logic signed [QW-1:0] q16_to_q24(input logic [31:0] v);
        return {{(QW-32-FRAC_SHIFT){v[31]}}, v, {FRAC_SHIFT{1'b0}}};
    endfunction

    // saturating add
    function automatic logic signed [QW-1:0] sat_add(input logic signed [QW-1:0] a,
                                                     input logic signed [QW-1:0] b);
        logic signed [QW:0] s;
        s = {a[QW-1], a} + {b[QW-1], b};
        if (s[QW] != s[QW-1])
            return s[QW] ? Q_MIN : Q_MAX;
        return s[QW-1:0];
    endfunction

    // saturating negate
    function automatic logic signed [QW-1:0] sat_neg(input logic signed [QW-1:0] a);
        if (a == Q_MIN)
            return Q_MAX;
        return -a;
    endfunction

endpackage

`default_nettype wire

>>> hdl/mmc_if.sv
// ----------------------------------------------------------------------------
// mmc_in_if / mmc_out_if
// Valid/ready channels for motor descriptions and coefficient words.
// ----------------------------------------------------------------------------
`default_nettype none

interface mmc_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  motor_column;
    logic [15:0] motor_kv;
    logic [21:0] supply_voltage;
    logic [15:0] signal_max;
    logic signed [15:0] tilt_angle;
    logic signed [15:0] azimuth_angle;
    logic signed [31:0] traction_gain;
    logic signed [31:0] torque_gain;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic        spins_positive;

    modport source (output valid, motor_column, motor_kv, supply_voltage, signal_max,
                    tilt_angle, azimuth_angle, traction_gain, torque_gain,
                    pos_x, pos_y, pos_z, spins_positive, input ready);
    modport sink (input valid, motor_column, motor_kv, supply_voltage, signal_max,
                  tilt_angle, azimuth_angle, traction_gain, torque_gain,
                  pos_x, pos_y, pos_z, spins_positive, output ready);
endinterface

interface mmc_out_if;
    logic        valid;
    logic        ready;
    logic signed [47:0] coefficient;
    logic [2:0]  row_index;
    logic [2:0]  axis_code;
    logic [2:0]  column_index;
    logic        last_of_motor;

    modport source (output valid, coefficient, row_index, axis_code, column_index,
                    last_of_motor, input ready);
    modport sink (input valid, coefficient, row_index, axis_code, column_index,
                  last_of_motor, output ready);
endinterface

`default_nettype wire

>>> hdl/multirotor_mixer_coefficients.sv
// ----------------------------------------------------------------------------
// multirotor_mixer_coefficients
// Throughput: a motor word enters every cycle the pipeline moves; the word
// serializer sends one coefficient per cycle while coef.ready is high, one
// word per enabled axis (0 to 6) of each motor, and so sets the motor rate.
// Reset clears all valid bits and the serializer; axis_enable resets to 63.
// ----------------------------------------------------------------------------
`default_nettype none

module multirotor_mixer_coefficients #(
    parameter int MAX_MOTORS = mmc_pkg::MAX_MOTORS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    mmc_in_if.sink           motor,
    mmc_out_if.source        coef,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int QW = mmc_pkg::QW;
    localparam int LQ = mmc_pkg::QMUL_LAT;
    localparam int NDS = mmc_pkg::DIV_STAGES;
    localparam int DB = mmc_pkg::DIV_BITS;
    localparam int DW = mmc_pkg::DIVW;
    localparam int NA = mmc_pkg::NAXES;
    localparam int T_R = 1 + NDS;
    localparam int T_TR2 = T_R + 2 * LQ;
    localparam int T_ANG = 2 + mmc_pkg::CORDIC_STAGES;
    localparam int D_RX = T_TR2 - T_ANG - LQ;
    localparam int D_CT = T_TR2 - T_ANG;
    localparam int T_V = T_TR2 + LQ;
    localparam int T_P = T_V + LQ;
    localparam int T_OUT = T_P + 2;

    // ---------------------------------------------------------------- config
    logic [5:0] axis_enable_reg, axis_enable_next;
    logic       cfg_wr;

    assign cfg_wr = psel && penable && pwrite && (paddr[2] == mmc_pkg::REG_AXIS_ENABLE);
    assign axis_enable_next = cfg_wr ? pwdata[5:0] : axis_enable_reg;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == mmc_pkg::REG_AXIS_ENABLE) ? {26'd0, axis_enable_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            axis_enable_reg <= mmc_pkg::AXIS_ENABLE_RST;
        else
            axis_enable_reg <= axis_enable_next;
    end

    // -------------------------------------------------------- pipeline flow
    logic adv;
    logic ser_free;
    logic [T_OUT:0] v_reg;

    assign adv = !v_reg[T_OUT] || ser_free;
    assign motor.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[T_OUT-1:0], motor.valid};
    end

    // input capture and side band line
    logic [15:0] kv_reg, smax_reg;
    logic [21:0] volt_reg;
    logic signed [15:0] tilt_reg, azim_reg;
    mmc_pkg::side_t side_reg [0:T_OUT];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kv_reg <= motor.motor_kv;
            volt_reg <= motor.supply_voltage;
            smax_reg <= motor.signal_max;
            tilt_reg <= motor.tilt_angle;
            azim_reg <= motor.azimuth_angle;
            side_reg[0] <= '{col: motor.motor_column, spin: motor.spins_positive,
                             tg: motor.traction_gain, cg: motor.torque_gain,
                             px: motor.pos_x, py: motor.pos_y, pz: motor.pos_z};
            for (int i = 1; i <= T_OUT; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    // ------------------------------------------------ speed factor divider
    logic [DW-1:0] w_reg [0:NDS];
    logic [15:0]   rem_reg [0:NDS];
    logic [15:0]   d_reg [0:NDS];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w_reg[0] <= DW'({38'(kv_reg) * 38'(volt_reg), 8'h00});
            rem_reg[0] <= '0;
            d_reg[0] <= (smax_reg == '0) ? 16'd1 : smax_reg;
        end
    end

    // restoring division, DB quotient bits per stage
    for (genvar s = 0; s < NDS; s++)
    begin : g_div
        logic [DW-1:0] wq [0:DB];
        logic [15:0]   rq [0:DB];
        logic [16:0]   trial;

        always_comb
        begin
            wq[0] = w_reg[s];
            rq[0] = rem_reg[s];
            trial = '0;
            for (int j = 0; j < DB; j++)
            begin
                trial = {rq[j], wq[j][DW-1]};
                wq[j+1] = {wq[j][DW-2:0], 1'b0};
                if (trial >= {1'b0, d_reg[s]})
                begin
                    trial = trial - {1'b0, d_reg[s]};
                    wq[j+1][0] = 1'b1;
                end
                rq[j+1] = trial[15:0];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                w_reg[s+1] <= wq[DB];
                rem_reg[s+1] <= rq[DB];
                d_reg[s+1] <= d_reg[s];
            end
        end
    end

    // --------------------------------------------------- thrust magnitudes
    logic signed [QW-1:0] r2, tr2, cr2;

    mmc_qmul u_r2 (.clk(clk), .en(adv), .a($signed(w_reg[NDS])),
                   .b($signed(w_reg[NDS])), .p(r2));
    mmc_qmul u_tr2 (.clk(clk), .en(adv), .a(mmc_pkg::q16_to_q24(side_reg[T_R+LQ].tg)),
                    .b(r2), .p(tr2));
    mmc_qmul u_cr2 (.clk(clk), .en(adv), .a(mmc_pkg::q16_to_q24(side_reg[T_R+LQ].cg)),
                    .b(r2), .p(cr2));

    // ------------------------------------------------------ thrust direction
    logic signed [QW-1:0] st, ct, sp, cp, rx, ry;
    logic signed [QW-1:0] rx_d [0:D_RX-1];
    logic signed [QW-1:0] ry_d [0:D_RX-1];
    logic signed [QW-1:0] ct_d [0:D_CT-1];

    mmc_cordic u_theta (.clk(clk), .en(adv), .angle(tilt_reg), .sin_q(st), .cos_q(ct));
    mmc_cordic u_phi (.clk(clk), .en(adv), .angle(azim_reg), .sin_q(sp), .cos_q(cp));

    mmc_qmul u_rx (.clk(clk), .en(adv), .a(cp), .b(st), .p(rx));
    mmc_qmul u_ry (.clk(clk), .en(adv), .a(sp), .b(st), .p(ry));

    // align direction with magnitudes
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rx_d[0] <= rx;
            ry_d[0] <= ry;
            ct_d[0] <= ct;
            for (int i = 1; i < D_RX; i++)
            begin
                rx_d[i] <= rx_d[i-1];
                ry_d[i] <= ry_d[i-1];
            end
            for (int i = 1; i < D_CT; i++)
                ct_d[i] <= ct_d[i-1];
        end
    end

    // ------------------------------------------------ forces and torques
    logic signed [QW-1:0] v0, v1, v2, m3, m4, m5;

    mmc_qmul u_v0 (.clk(clk), .en(adv), .a(rx_d[D_RX-1]), .b(tr2), .p(v0));
    mmc_qmul u_v1 (.clk(clk), .en(adv), .a(ry_d[D_RX-1]), .b(tr2), .p(v1));
    mmc_qmul u_v2 (.clk(clk), .en(adv), .a(ct_d[D_CT-1]), .b(tr2), .p(v2));
    mmc_qmul u_m3 (.clk(clk), .en(adv), .a(rx_d[D_RX-1]), .b(cr2), .p(m3));
    mmc_qmul u_m4 (.clk(clk), .en(adv), .a(ry_d[D_RX-1]), .b(cr2), .p(m4));
    mmc_qmul u_m5 (.clk(clk), .en(adv), .a(ct_d[D_CT-1]), .b(cr2), .p(m5));

    // lever arm products
    logic signed [QW-1:0] px_q, py_q, pz_q;
    logic signed [QW-1:0] p_py_v2, p_pz_v1, p_pz_v0, p_px_v2, p_px_v1, p_py_v0;

    assign px_q = mmc_pkg::q16_to_q24(side_reg[T_V].px);
    assign py_q = mmc_pkg::q16_to_q24(side_reg[T_V].py);
    assign pz_q = mmc_pkg::q16_to_q24(side_reg[T_V].pz);

    mmc_qmul u_p0 (.clk(clk), .en(adv), .a(py_q), .b(v2), .p(p_py_v2));
    mmc_qmul u_p1 (.clk(clk), .en(adv), .a(pz_q), .b(v1), .p(p_pz_v1));
    mmc_qmul u_p2 (.clk(clk), .en(adv), .a(pz_q), .b(v0), .p(p_pz_v0));
    mmc_qmul u_p3 (.clk(clk), .en(adv), .a(px_q), .b(v2), .p(p_px_v2));
    mmc_qmul u_p4 (.clk(clk), .en(adv), .a(px_q), .b(v1), .p(p_px_v1));
    mmc_qmul u_p5 (.clk(clk), .en(adv), .a(py_q), .b(v0), .p(p_py_v0));

    // hold reaction torques until the moment sums, forces until the serializer load
    logic signed [QW-1:0] f_d [0:T_OUT-T_V-1][0:2];
    logic signed [QW-1:0] m_d [0:LQ-1][0:2];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_d[0][0] <= v0;
            f_d[0][1] <= v1;
            f_d[0][2] <= v2;
            m_d[0][0] <= m3;
            m_d[0][1] <= m4;
            m_d[0][2] <= m5;
            for (int i = 1; i < T_OUT - T_V; i++)
                f_d[i] <= f_d[i-1];
            for (int i = 1; i < LQ; i++)
                m_d[i] <= m_d[i-1];
        end
    end

    // moment sums, two saturating adds in two stages
    logic                 spin;
    logic signed [QW-1:0] a3_reg, a4_reg, a5_reg, n3_reg, n4_reg, n5_reg;
    logic signed [QW-1:0] v3_reg, v4_reg, v5_reg;

    assign spin = side_reg[T_P].spin;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a3_reg <= mmc_pkg::sat_add(spin ? mmc_pkg::sat_neg(m_d[LQ-1][0]) : m_d[LQ-1][0],
                                       p_py_v2);
            a4_reg <= mmc_pkg::sat_add(spin ? m_d[LQ-1][1] : mmc_pkg::sat_neg(m_d[LQ-1][1]),
                                       p_pz_v0);
            a5_reg <= mmc_pkg::sat_add(spin ? mmc_pkg::sat_neg(m_d[LQ-1][2]) : m_d[LQ-1][2],
                                       p_px_v1);
            n3_reg <= mmc_pkg::sat_neg(p_pz_v1);
            n4_reg <= mmc_pkg::sat_neg(p_px_v2);
            n5_reg <= mmc_pkg::sat_neg(p_py_v0);
            v3_reg <= mmc_pkg::sat_add(a3_reg, n3_reg);
            v4_reg <= mmc_pkg::sat_add(a4_reg, n4_reg);
            v5_reg <= mmc_pkg::sat_add(a5_reg, n5_reg);
        end
    end

    // ------------------------------------------------------ word serializer
    logic signed [QW-1:0] vals_reg [0:NA-1];
    logic [2:0]    col_reg;
    logic [NA-1:0] rem_mask_reg, rem_mask_next, rest, mask_new;
    logic [2:0]    row_reg, row_next, idx;
    logic          take, load, last;

    always_comb
    begin
        idx = mmc_pkg::AXIS_X;
        for (int k = NA - 1; k >= 0; k--)
        begin
            if (rem_mask_reg[k])
                idx = 3'(k);
        end
        rest = rem_mask_reg & ~(NA'(1) << idx);
        last = (rest == '0);
    end

    assign take = coef.valid && coef.ready;
    assign ser_free = !coef.valid || (coef.ready && last);
    assign load = adv && v_reg[T_OUT];
    assign mask_new = (32'(side_reg[T_OUT].col) >= MAX_MOTORS) ? '0 : axis_enable_reg;

    always_comb
    begin
        rem_mask_next = rem_mask_reg;
        row_next = row_reg;
        if (load)
        begin
            rem_mask_next = mask_new;
            row_next = '0;
        end
        else if (take)
        begin
            rem_mask_next = rest;
            row_next = row_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_mask_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            rem_mask_reg <= rem_mask_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            vals_reg[mmc_pkg::AXIS_X] <= f_d[T_OUT-T_V-1][0];
            vals_reg[mmc_pkg::AXIS_Y] <= f_d[T_OUT-T_V-1][1];
            vals_reg[mmc_pkg::AXIS_Z] <= f_d[T_OUT-T_V-1][2];
            vals_reg[mmc_pkg::AXIS_ROLL] <= v3_reg;
            vals_reg[mmc_pkg::AXIS_PITCH] <= v4_reg;
            vals_reg[mmc_pkg::AXIS_YAW] <= v5_reg;
            col_reg <= side_reg[T_OUT].col;
        end
    end

    assign coef.valid = (rem_mask_reg != '0);
    assign coef.coefficient = vals_reg[idx];
    assign coef.row_index = row_reg;
    assign coef.axis_code = idx;
    assign coef.column_index = col_reg;
    assign coef.last_of_motor = last;

    // ------------------------------------------------------------ checks
    a_row_le_axis: assert property (@(posedge clk) disable iff (!rst_n)
        coef.valid |-> (coef.row_index <= coef.axis_code))
        else $error("row index ahead of axis code");

    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !motor.ready |-> coef.valid)
        else $error("input stalled while serializer idle");

    a_more_words: assert property (@(posedge clk) disable iff (!rst_n)
        (coef.valid && coef.ready && !coef.last_of_motor) |=> coef.valid)
        else $error("motor words cut short");

endmodule

`default_nettype wire

>>> hdl/mmc_qmul.sv
// ----------------------------------------------------------------------------
// mmc_qmul
// Pipelined Q24.24 multiply, magnitude truncated toward zero, saturated.
// Four stages: magnitude, partial products, sum, saturate and sign.
// ----------------------------------------------------------------------------
`default_nettype none

module mmc_qmul (
    input  wire logic                           clk,
    input  wire logic                           en,
    input  wire logic signed [mmc_pkg::QW-1:0]  a,
    input  wire logic signed [mmc_pkg::QW-1:0]  b,
    output logic signed [mmc_pkg::QW-1:0]       p
);

    localparam int QW = mmc_pkg::QW;
    localparam int H = QW / 2;

    logic [QW-1:0] ua_reg, ub_reg;
    logic          neg_a_reg, neg_b_reg, neg_c_reg;
    logic [QW-1:0] hh_reg, hb_reg, lb_reg, ll_reg;
    logic [QW+1:0] sum_reg;
    logic          big_reg;
    logic signed [QW-1:0] p_reg;
    logic [QW+1:0] lim;
    logic [QW-1:0] mag;

    // magnitudes and result sign
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ua_reg <= a[QW-1] ? QW'(-a) : QW'(a);
            ub_reg <= b[QW-1] ? QW'(-b) : QW'(b);
            neg_a_reg <= a[QW-1] ^ b[QW-1];
        end
    end

    // four half-width partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hh_reg <= ua_reg[QW-1:H] * ub_reg[QW-1:H];
            hb_reg <= ua_reg[QW-1:H] * ub_reg[H-1:0];
            lb_reg <= ua_reg[H-1:0] * ub_reg[QW-1:H];
            ll_reg <= ua_reg[H-1:0] * ub_reg[H-1:0];
            neg_b_reg <= neg_a_reg;
        end
    end

    // combine into the Q24.24 magnitude
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            big_reg <= (hh_reg >= (QW'(1) << (H - 1)));
            sum_reg <= ((QW+2)'(hh_reg[H-2:0]) << H) + (QW+2)'(hb_reg)
                       + (QW+2)'(lb_reg) + (QW+2)'(ll_reg[QW-1:H]);
            neg_c_reg <= neg_b_reg;
        end
    end

    // clamp to the signed range, restore sign
    always_comb
    begin
        lim = ((QW+2)'(1) << (QW - 1)) - (QW+2)'(!neg_c_reg);
        mag = (big_reg || sum_reg > lim) ? lim[QW-1:0] : sum_reg[QW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            p_reg <= neg_c_reg ? $signed(-mag) : $signed(mag);
    end

    assign p = p_reg;

endmodule

`default_nettype wire

>>> hdl/mmc_cordic.sv
// ----------------------------------------------------------------------------
// mmc_cordic
// Pipelined rotation-mode sine and cosine of a Q3.13 angle, 24 fraction bits,
// quadrant folding by pi, two micro-rotations per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module mmc_cordic (
    input  wire logic                           clk,
    input  wire logic                           en,
    input  wire logic signed [15:0]             angle,
    output logic signed [mmc_pkg::QW-1:0]       sin_q,
    output logic signed [mmc_pkg::QW-1:0]       cos_q
);

    localparam int CW = mmc_pkg::CW;
    localparam int QW = mmc_pkg::QW;
    localparam int NS = mmc_pkg::CORDIC_STAGES;
    localparam int PER = mmc_pkg::CORDIC_PER_STAGE;

    logic signed [CW-1:0] x_reg [0:NS];
    logic signed [CW-1:0] y_reg [0:NS];
    logic signed [CW-1:0] z_reg [0:NS];
    logic                 flip_reg [0:NS];
    logic signed [CW-1:0] z0;
    logic signed [QW-1:0] sin_reg, cos_reg;
    logic signed [QW-1:0] xe, ye;

    // fold the angle into [-pi/2, pi/2]
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= mmc_pkg::CORDIC_GAIN;
            y_reg[0] <= '0;
            if (z0 > mmc_pkg::HALF_PI_Q24)
            begin
                z_reg[0] <= z0 - mmc_pkg::PI_Q24;
                flip_reg[0] <= 1'b1;
            end
            else if (z0 < -mmc_pkg::HALF_PI_Q24)
            begin
                z_reg[0] <= z0 + mmc_pkg::PI_Q24;
                flip_reg[0] <= 1'b1;
            end
            else
            begin
                z_reg[0] <= z0;
                flip_reg[0] <= 1'b0;
            end
        end
    end

    assign z0 = CW'(angle) <<< mmc_pkg::ANG_SHIFT;

    // micro-rotation stages
    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        logic signed [CW-1:0] xs [0:PER];
        logic signed [CW-1:0] ys [0:PER];
        logic signed [CW-1:0] zs [0:PER];

        always_comb
        begin
            xs[0] = x_reg[s];
            ys[0] = y_reg[s];
            zs[0] = z_reg[s];
            for (int j = 0; j < PER; j++)
            begin
                if (!zs[j][CW-1])
                begin
                    xs[j+1] = xs[j] - (ys[j] >>> (s * PER + j));
                    ys[j+1] = ys[j] + (xs[j] >>> (s * PER + j));
                    zs[j+1] = zs[j] - mmc_pkg::cordic_atan(s * PER + j);
                end
                else
                begin
                    xs[j+1] = xs[j] + (ys[j] >>> (s * PER + j));
                    ys[j+1] = ys[j] - (xs[j] >>> (s * PER + j));
                    zs[j+1] = zs[j] + mmc_pkg::cordic_atan(s * PER + j);
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[s+1] <= xs[PER];
                y_reg[s+1] <= ys[PER];
                z_reg[s+1] <= zs[PER];
                flip_reg[s+1] <= flip_reg[s];
            end
        end
    end

    // undo the fold, widen to Q24.24
    assign xe = QW'(x_reg[NS]);
    assign ye = QW'(y_reg[NS]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= flip_reg[NS] ? -ye : ye;
            cos_reg <= flip_reg[NS] ? -xe : xe;
        end
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

`default_nettype wire

>>> verif/multirotor_mixer_coefficients_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multirotor_mixer_coefficients_tb
// Sends motor descriptions through the valid/ready motor channel and checks
// every coefficient word against a fixed point predictor of the mixer. The
// axis enable register is written over APB between phases while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module multirotor_mixer_coefficients_tb;

    localparam int CLK_HALF = 6;
    localparam int RST_CYCLES = 12;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 48;
    localparam int HOLD_CYCLES = 300;
    localparam logic [2:0] AXIS_ENABLE_ADDR = 3'd0;
    localparam longint SAT_HI = 64'sd140737488355327;
    localparam longint SAT_LO = -64'sd140737488355328;
    localparam longint ANGLE_PI = 52707179;
    localparam longint ANGLE_HALF_PI = 26353589;
    localparam longint ROT_GAIN = 10188014;
    localparam longint ATAN_TBL [24] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2};

    typedef struct {
        logic [2:0]  idx;
        logic [15:0] kv;
        logic [21:0] volt;
        logic [15:0] smax;
        logic [15:0] tilt;
        logic [15:0] azim;
        logic [31:0] tg;
        logic [31:0] cg;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic        spin;
    } motor_t;

    typedef struct {
        logic [47:0] coef;
        logic [2:0]  row;
        logic [2:0]  axis;
        logic [2:0]  col;
        logic        last;
    } coef_word_t;

    // expected coefficient words and mixer predictor
    class coef_scoreboard;
        coef_word_t coef_q[$];
        logic [5:0] axis_en = mmc_pkg::AXIS_ENABLE_RST;
        int errors = 0;

        function longint clip(longint v);
            if (v > SAT_HI) return SAT_HI;
            if (v < SAT_LO) return SAT_LO;
            return v;
        endfunction

        // Q24.24 product, magnitude truncated, saturated
        function longint qprod(longint a, longint b);
            bit neg;
            longint unsigned ua, ub, lim, ah, al, bh, bl, hh, r;
            neg = (a < 0) != (b < 0);
            ua = (a < 0) ? -a : a;
            ub = (b < 0) ? -b : b;
            lim = neg ? 64'd140737488355328 : 64'd140737488355327;
            ah = ua >> 24; al = ua & 64'hFFFFFF;
            bh = ub >> 24; bl = ub & 64'hFFFFFF;
            hh = ah * bh;
            if (hh >= (64'd1 << 23))
                r = lim;
            else
            begin
                r = (hh << 24) + ah * bl + al * bh + ((al * bl) >> 24);
                if (r > lim) r = lim;
            end
            return neg ? -longint'(r) : longint'(r);
        endfunction

        // rotation with quadrant fold, 24 fraction bits
        function void rotate(logic [15:0] ang, output longint sn, output longint cs);
            longint z, x, y, dx, dy;
            bit flip;
            z = longint'($signed(ang)) * 2048;
            x = ROT_GAIN; y = 0; flip = 0;
            if (z > ANGLE_HALF_PI)
            begin
                z -= ANGLE_PI; flip = 1;
            end
            else if (z < -ANGLE_HALF_PI)
            begin
                z += ANGLE_PI; flip = 1;
            end
            for (int i = 0; i < 24; i++)
            begin
                dx = y >>> i; dy = x >>> i;
                if (z >= 0)
                begin
                    x -= dx; y += dy; z -= ATAN_TBL[i];
                end
                else
                begin
                    x += dx; y -= dy; z += ATAN_TBL[i];
                end
            end
            sn = flip ? -y : y;
            cs = flip ? -x : x;
        endfunction

        function void note_motor(motor_t m);
            longint unsigned sm;
            longint r, r2, tr2, cr2, st, ct, sp, cp, rx, ry, rz, s;
            longint tg, cg, px, py, pz;
            longint v [6];
            coef_word_t w;
            int n;
            if (axis_en == 0) return;
            sm = (m.smax == 0) ? 64'd1 : 64'(m.smax);
            tg = longint'($signed(m.tg)) * 256; cg = longint'($signed(m.cg)) * 256;
            px = longint'($signed(m.px)) * 256; py = longint'($signed(m.py)) * 256;
            pz = longint'($signed(m.pz)) * 256;
            s = m.spin ? 1 : -1;
            r = longint'((longint'(m.kv) * longint'(m.volt) * 256) / sm);
            r2 = qprod(r, r);
            tr2 = qprod(tg, r2);
            cr2 = qprod(cg, r2);
            rotate(m.tilt, st, ct);
            rotate(m.azim, sp, cp);
            rx = qprod(cp, st);
            ry = qprod(sp, st);
            rz = ct;
            v[0] = qprod(rx, tr2);
            v[1] = qprod(ry, tr2);
            v[2] = qprod(rz, tr2);
            v[3] = clip(clip(clip(-s * qprod(rx, cr2)) + qprod(py, v[2]))
                        + clip(-qprod(pz, v[1])));
            v[4] = clip(clip(clip(s * qprod(ry, cr2)) + qprod(pz, v[0]))
                        + clip(-qprod(px, v[2])));
            v[5] = clip(clip(clip(-s * qprod(rz, cr2)) + qprod(px, v[1]))
                        + clip(-qprod(py, v[0])));
            n = 0;
            for (int k = 0; k < mmc_pkg::NAXES; k++)
            begin
                if (axis_en[k])
                begin
                    w.coef = v[k][47:0];
                    w.row = n[2:0];
                    w.axis = k[2:0];
                    w.col = m.idx;
                    w.last = 0;
                    coef_q.push_back(w);
                    n++;
                end
            end
            coef_q[coef_q.size() - 1].last = 1;
        endfunction

        function void check_coef(coef_word_t got);
            coef_word_t exp_w;
            if (coef_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected coefficient word %h row %0d axis %0d",
                             got.coef, got.row, got.axis);
                return;
            end
            exp_w = coef_q.pop_front();
            if (got.coef !== exp_w.coef || got.row !== exp_w.row
                || got.axis !== exp_w.axis || got.col !== exp_w.col
                || got.last !== exp_w.last)
            begin
                errors++;
                if (errors <= 10)
                    $display("word mismatch: exp coef %h row %0d axis %0d col %0d last %0d,",
                             exp_w.coef, exp_w.row, exp_w.axis, exp_w.col, exp_w.last,
                             " got coef %h row %0d axis %0d col %0d last %0d",
                             got.coef, got.row, got.axis, got.col, got.last);
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    mmc_in_if motor_ch ();
    mmc_out_if coef_ch ();

    coef_scoreboard sb = new();
    int cycles = 0;
    bit idle_on = 1;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;

    multirotor_mixer_coefficients dut (
        .clk(clk), .rst_n(rst_n), .motor(motor_ch.sink), .coef(coef_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #(CLK_HALF) clk = ~clk;

    initial
    begin
        motor_ch.valid = 0;
        motor_ch.motor_column = 0; motor_ch.motor_kv = 0; motor_ch.supply_voltage = 0;
        motor_ch.signal_max = 1; motor_ch.tilt_angle = 0; motor_ch.azimuth_angle = 0;
        motor_ch.traction_gain = 0; motor_ch.torque_gain = 0;
        motor_ch.pos_x = 0; motor_ch.pos_y = 0; motor_ch.pos_z = 0;
        motor_ch.spins_positive = 0;
        coef_ch.ready = 0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("multirotor_mixer_coefficients: mismatch");
            $finish;
        end
    end

    // receiver ready with random stalls and long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            coef_ch.ready <= 0;
        else if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            coef_ch.ready <= 0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            coef_ch.ready <= 0;
        end
        else
            coef_ch.ready <= !(idle_on && $urandom_range(0, 99) < 19);
    end

    // accepted motor words and coefficient words
    always @(posedge clk)
    begin
        motor_t m;
        coef_word_t w;
        if (rst_n && motor_ch.valid && motor_ch.ready)
        begin
            m.idx = motor_ch.motor_column; m.kv = motor_ch.motor_kv;
            m.volt = motor_ch.supply_voltage; m.smax = motor_ch.signal_max;
            m.tilt = motor_ch.tilt_angle; m.azim = motor_ch.azimuth_angle;
            m.tg = motor_ch.traction_gain; m.cg = motor_ch.torque_gain;
            m.px = motor_ch.pos_x; m.py = motor_ch.pos_y; m.pz = motor_ch.pos_z;
            m.spin = motor_ch.spins_positive;
            sb.note_motor(m);
        end
        if (rst_n && coef_ch.valid && coef_ch.ready)
        begin
            w.coef = coef_ch.coefficient; w.row = coef_ch.row_index;
            w.axis = coef_ch.axis_code; w.col = coef_ch.column_index;
            w.last = coef_ch.last_of_motor;
            sb.check_coef(w);
        end
    end

    task automatic send_motor(motor_t m);
        while (idle_on && $urandom_range(0, 99) < 19)
        begin
            motor_ch.valid <= 0;
            @(posedge clk);
        end
        motor_ch.valid <= 1;
        motor_ch.motor_column <= m.idx; motor_ch.motor_kv <= m.kv;
        motor_ch.supply_voltage <= m.volt; motor_ch.signal_max <= m.smax;
        motor_ch.tilt_angle <= m.tilt; motor_ch.azimuth_angle <= m.azim;
        motor_ch.traction_gain <= m.tg; motor_ch.torque_gain <= m.cg;
        motor_ch.pos_x <= m.px; motor_ch.pos_y <= m.py; motor_ch.pos_z <= m.pz;
        motor_ch.spins_positive <= m.spin;
        do
            @(posedge clk);
        while (!(motor_ch.valid && motor_ch.ready));
    endtask

    task automatic stop_and_drain();
        motor_ch.valid <= 0;
        @(posedge clk);
        while (sb.coef_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // register write, setup then access cycle
    task automatic write_axis_enable(logic [5:0] en);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= AXIS_ENABLE_ADDR; pwdata <= {26'd0, en};
        @(posedge clk);
        penable <= 1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.axis_en = en;
        @(posedge clk);
    endtask

    function automatic motor_t random_motor();
        motor_t m;
        m.idx = 3'($urandom); m.spin = 1'($urandom);
        if ($urandom_range(0, 99) < 70)
        begin
            // plausible airframe values
            m.kv = 16'($urandom_range(200, 3000));
            m.volt = 22'($urandom_range(6 << 16, 50 << 16));
            m.smax = 16'($urandom_range(500, 4000));
            m.tilt = 16'($urandom_range(0, 8192) - 4096);
            m.azim = 16'($urandom);
            m.tg = $urandom_range(0, 4000) - 2000;
            m.cg = $urandom_range(0, 400) - 200;
            m.px = $urandom_range(0, 65536) - 32768;
            m.py = $urandom_range(0, 65536) - 32768;
            m.pz = $urandom_range(0, 16384) - 8192;
        end
        else
        begin
            m.kv = 16'($urandom); m.volt = 22'($urandom); m.smax = 16'($urandom);
            m.tilt = 16'($urandom); m.azim = 16'($urandom);
            m.tg = $urandom; m.cg = $urandom;
            m.px = $urandom; m.py = $urandom; m.pz = $urandom;
        end
        return m;
    endfunction

    function automatic motor_t edge_motor(int k);
        motor_t m;
        m = '{idx: k[2:0], kv: 16'd1000, volt: 22'd786432, smax: 16'd1000,
              tilt: 16'd1000, azim: 16'd3000, tg: 32'd500, cg: 32'd50,
              px: 32'd16384, py: -32'sd16384, pz: 32'd2000, spin: k[0]};
        case (k)
            0: m.kv = 16'd0;
            1: m.smax = 16'd0;
            2: begin m.kv = 16'hFFFF; m.volt = 22'h3FFFFF; m.smax = 16'd1; end
            3: m.smax = 16'hFFFF;
            4: m.tilt = 16'h7FFF;
            5: m.tilt = 16'h8000;
            6: begin m.azim = 16'h7FFF; m.tilt = 16'd12868; end
            7: begin m.azim = 16'h8000; m.tilt = -16'sd12868; end
            8: begin m.tilt = 16'd0; m.azim = 16'd0; end
            9: begin m.tg = 32'h7FFFFFFF; m.cg = 32'h80000000; end
            10: begin m.tg = 32'h80000000; m.cg = 32'h7FFFFFFF; end
            11: begin m.px = 32'h7FFFFFFF; m.py = 32'h80000000; m.pz = 32'h7FFFFFFF; end
            12: begin m.px = 32'h80000000; m.py = 32'h7FFFFFFF; m.pz = 32'h80000000;
                      m.kv = 16'hFFFF; m.tg = 32'h7FFFFFFF; end
            13: begin m.tg = 32'd0; m.cg = 32'd0; end
            default: m.spin = ~m.spin;
        endcase
        return m;
    endfunction

    initial
    begin
        logic [5:0] en_list [7];
        en_list = '{6'd63, 6'd0, 6'd1, 6'd32, 6'd21, 6'd42, 6'd63};
        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed edges at reset setting
        for (int k = 0; k < 16; k++)
            send_motor(edge_motor(k));
        stop_and_drain();

        for (int ph = 0; ph < 7; ph++)
        begin
            if (ph == 6)
                en_list[ph] = 6'($urandom_range(1, 62));
            write_axis_enable(en_list[ph]);
            if (ph == 2)
            begin
                // long receiver hold-off with a busy sender
                idle_on = 0;
                hold_req <= hold_req + 1;
                for (int i = 0; i < 25; i++)
                    send_motor(random_motor());
                idle_on = 1;
            end
            else
            begin
                for (int i = 0; i < 12; i++)
                begin
                    send_motor(random_motor());
                    if (ph == 4 && i == 7)
                    begin
                        // sender waits for every word to come back
                        motor_ch.valid <= 0;
                        @(posedge clk);
                        while (sb.coef_q.size() != 0)
                            @(posedge clk);
                    end
                end
            end
            stop_and_drain();
        end

        if (sb.errors == 0)
            $display("multirotor_mixer_coefficients: match");
        else
            $display("multirotor_mixer_coefficients: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
